FILE: src/rotate_1bpp_bitmap_defines.svh
// Assertion macros used by the rotate_1bpp_bitmap top level.
`ifndef ROTATE_1BPP_BITMAP_DEFINES_SVH
`define ROTATE_1BPP_BITMAP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ROT1_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ROT1_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/rot1_pkg.sv
// Package with constants, types and helper functions of the bitmap rotator.
`default_nettype none

package rot1_pkg;

  // Image and store geometry.
  localparam int MAX_SIDE     = 128;
  localparam int STORE_BYTES  = 2048;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int SIDE_W       = $clog2(MAX_SIDE) + 1;
  localparam int COORD_W      = $clog2(MAX_SIDE);
  localparam int PIX_PER_BYTE = 8;
  localparam int PIX_W        = $clog2(PIX_PER_BYTE);
  localparam int ROWB_W       = $clog2(MAX_SIDE / PIX_PER_BYTE) + 1;
  localparam int BX_W         = $clog2(MAX_SIDE / PIX_PER_BYTE);
  localparam int SIZE_W       = ROWB_W + SIDE_W;
  localparam int DATA_W       = 8;

  // Item operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Rotation codes.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [1:0]        RESET_ROTATION = ROT_0;
  localparam logic [SIDE_W-1:0] RESET_WIDTH    = SIDE_W'(128);
  localparam logic [SIDE_W-1:0] RESET_HEIGHT   = SIDE_W'(64);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ZWAIT,
    S_DIV,
    S_GATHER,
    S_DRAIN,
    S_DONE
  } state_t;

  // A side of zero counts as one, a side above the maximum counts as the maximum.
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end
    return r;
  endfunction

  // Bytes in one padded row of the given pixel width.
  function automatic logic [ROWB_W-1:0] bytes_per_row(input logic [SIDE_W-1:0] side);
    logic [SIDE_W:0] sum;
    sum = {1'b0, side} + (SIDE_W + 1)'(PIX_PER_BYTE - 1);
    return ROWB_W'(sum >> PIX_W);
  endfunction

endpackage

`default_nettype wire

FILE: src/rot1_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module rot1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: a write, or a read whose data shows next cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/rotate_1bpp_bitmap.sv
// Top level of the 1-bit-per-pixel bitmap rotator.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     operation, byte_address, write_byte
// out       output     out_valid / out_ready   read_byte, out_of_range
// cfg       input      cfg_write               cfg_index, cfg_data
//
// A write item is stored from IDLE and another item may follow at once.
// A read at rotation zero passes CHECK, ZWAIT and DONE, a read past the image
// CHECK and DONE. Any other read does a 7-step divide of the address by the row
// length, then up to 8 pixel reads through the single store port, one per cycle.
// Reset clears control and configuration only; the store is not cleared.
// A stalled output holds its item; the next item is still taken meanwhile.
`default_nettype none

module rotate_1bpp_bitmap (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [10:0] byte_address,
  input  wire logic [7:0]  write_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  read_byte,
  output logic             out_of_range,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  `include "rotate_1bpp_bitmap_defines.svh"

  localparam int AW = rot1_pkg::ADDR_W;
  localparam int SW = rot1_pkg::SIDE_W;
  localparam int CW = rot1_pkg::COORD_W;
  localparam int PW = rot1_pkg::PIX_W;
  localparam int RW = rot1_pkg::ROWB_W;
  localparam int BW = rot1_pkg::BX_W;
  localparam int ZW = rot1_pkg::SIZE_W;
  localparam int DW = rot1_pkg::DATA_W;

  // Configuration registers.
  logic [1:0]    rotation_steps;
  logic [SW-1:0] source_width;
  logic [SW-1:0] source_height;

  // Sequencer and datapath registers.
  rot1_pkg::state_t state, state_next;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] rem;
  logic [CW-1:0] quot;
  logic [PW-1:0] step;
  logic [PW-1:0] bcnt;
  logic [DW-1:0] res;
  logic          oor_q;
  logic          pend_valid;
  logic [PW-1:0] pend_bit;
  logic [PW-1:0] pend_sel;

  // Derived geometry and addressing.
  logic [SW-1:0] w_c, h_c, nw, nh;
  logic [RW-1:0] rb, nrb;
  logic [ZW-1:0] img_size;
  logic          is_oor;
  logic [AW-1:0] trial;
  logic [CW-1:0] nx;
  logic          nx_ok;
  logic [SW-1:0] sx_full, sy_full;
  logic [CW-1:0] sx, sy;
  logic [AW:0]   row_base;
  logic [AW:0]   gather_sum;
  logic [AW-1:0] gather_addr;

  // Store port and output control.
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_rdata;
  logic          load_out;

  // Conditions watched by the checks.
  logic          rd_take;
  logic          in_gather;
  logic          oor_out;
  logic          out_stall;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_steps <= rot1_pkg::RESET_ROTATION;
      source_width   <= rot1_pkg::RESET_WIDTH;
      source_height  <= rot1_pkg::RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rot1_pkg::REG_ROTATION: rotation_steps <= cfg_data[1:0];
        rot1_pkg::REG_WIDTH:    source_width   <= cfg_data;
        rot1_pkg::REG_HEIGHT:   source_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Source and rotated image geometry.
  always_comb begin
    w_c = rot1_pkg::clamp_side(source_width);
    h_c = rot1_pkg::clamp_side(source_height);
    rb  = rot1_pkg::bytes_per_row(w_c);
    if (rotation_steps == rot1_pkg::ROT_90 || rotation_steps == rot1_pkg::ROT_270) begin
      nw = h_c;
      nh = w_c;
    end else begin
      nw = w_c;
      nh = h_c;
    end
    nrb      = rot1_pkg::bytes_per_row(nw);
    img_size = ZW'(nrb) * ZW'(nh);
    is_oor   = ZW'(addr_q) >= img_size;
  end

  // Divisor shifted to the current quotient bit.
  assign trial = AW'(nrb) << step;

  // Pixel coordinates: quot is the rotated row, rem the byte in that row.
  always_comb begin
    nx    = {rem[BW-1:0], bcnt};
    nx_ok = SW'(nx) < nw;
    unique case (rotation_steps)
      rot1_pkg::ROT_90: begin
        sx_full = SW'(quot);
        sy_full = h_c - SW'(1) - SW'(nx);
      end
      rot1_pkg::ROT_180: begin
        sx_full = w_c - SW'(1) - SW'(nx);
        sy_full = h_c - SW'(1) - SW'(quot);
      end
      default: begin
        sx_full = w_c - SW'(1) - SW'(quot);
        sy_full = SW'(nx);
      end
    endcase
    sx          = sx_full[CW-1:0];
    sy          = sy_full[CW-1:0];
    row_base    = (AW + 1)'(sy) * (AW + 1)'(rb);
    gather_sum  = row_base + (AW + 1)'(sx >> PW);
    gather_addr = gather_sum[AW-1:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rot1_pkg::S_IDLE: begin
        if (in_valid && operation == rot1_pkg::OP_READ) begin
          state_next = rot1_pkg::S_CHECK;
        end
      end
      rot1_pkg::S_CHECK: begin
        priority if (is_oor) begin
          state_next = rot1_pkg::S_DONE;
        end else if (rotation_steps == rot1_pkg::ROT_0) begin
          state_next = rot1_pkg::S_ZWAIT;
        end else begin
          state_next = rot1_pkg::S_DIV;
        end
      end
      rot1_pkg::S_ZWAIT: state_next = rot1_pkg::S_DONE;
      rot1_pkg::S_DIV: begin
        if (step == '0) begin
          state_next = rot1_pkg::S_GATHER;
        end
      end
      rot1_pkg::S_GATHER: begin
        if (bcnt == PW'(rot1_pkg::PIX_PER_BYTE - 1)) begin
          state_next = rot1_pkg::S_DRAIN;
        end
      end
      rot1_pkg::S_DRAIN: state_next = rot1_pkg::S_DONE;
      rot1_pkg::S_DONE: begin
        if (load_out) begin
          state_next = rot1_pkg::S_IDLE;
        end
      end
      default: state_next = rot1_pkg::S_IDLE;
    endcase
  end

  // Handshake and store port per state.
  always_comb begin
    in_ready = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = byte_address;
    load_out = 1'b0;
    unique case (state)
      rot1_pkg::S_IDLE: begin
        in_ready = 1'b1;
        ram_en   = in_valid && operation == rot1_pkg::OP_WRITE;
        ram_we   = 1'b1;
      end
      rot1_pkg::S_CHECK: begin
        ram_en   = 1'b1;
        ram_addr = addr_q;
      end
      rot1_pkg::S_GATHER: begin
        ram_en   = nx_ok;
        ram_addr = gather_addr;
      end
      rot1_pkg::S_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rot1_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Source store.
  rot1_ram #(
    .WIDTH(DW),
    .DEPTH(rot1_pkg::STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(write_byte),
    .rdata(ram_rdata)
  );

  // Pending pixel read tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= state == rot1_pkg::S_GATHER && nx_ok;
    end
  end

  // Address capture, address divide, pixel gather and result assembly.
  always_ff @(posedge clk) begin
    if (state == rot1_pkg::S_IDLE) begin
      addr_q <= byte_address;
    end
    if (state == rot1_pkg::S_CHECK) begin
      rem   <= addr_q;
      quot  <= '0;
      step  <= PW'(CW - 1);
      oor_q <= is_oor;
      res   <= '0;
    end
    if (state == rot1_pkg::S_ZWAIT) begin
      res <= ram_rdata;
    end
    if (state == rot1_pkg::S_DIV) begin
      if (rem >= trial) begin
        rem        <= rem - trial;
        quot[step] <= 1'b1;
      end
      step <= step - PW'(1);
      bcnt <= '0;
    end
    if (state == rot1_pkg::S_GATHER) begin
      pend_bit <= bcnt;
      pend_sel <= sx[PW-1:0];
      bcnt     <= bcnt + PW'(1);
    end
    if (pend_valid) begin
      res[~pend_bit] <= ram_rdata[~pend_sel];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_byte    <= res;
      out_of_range <= oor_q;
    end
  end

  // Checks on sequencing and results.
  assign rd_take   = in_valid && in_ready && operation == rot1_pkg::OP_READ;
  assign in_gather = state == rot1_pkg::S_GATHER;
  assign oor_out   = out_valid && out_of_range;
  assign out_stall = state == rot1_pkg::S_DONE && out_valid && !out_ready;

  `ROT1_ASSERT_NEXT(a_read_busy, clk, rst, rd_take, !in_ready, "read item did not block input")
  `ROT1_ASSERT_NOW(a_oor_zero, clk, rst, oor_out, read_byte == '0, "past-end item has data")
  `ROT1_ASSERT_NEXT(a_pend_src, clk, rst, !in_gather, !pend_valid, "stray pixel read")
  `ROT1_ASSERT_NEXT(a_done_hold, clk, rst, out_stall, state == rot1_pkg::S_DONE, "result dropped")

endmodule

`default_nettype wire
